// ===== rtl/phd_pkg.sv =====
`default_nettype none
package phd_pkg;

    localparam int HDR_BYTES   = 12;
    localparam int HDR_CNT_W   = $clog2(HDR_BYTES);
    localparam int OFS_MAGIC   = 0;
    localparam int OFS_VERSION = 4;
    localparam int OFS_TYPE    = 5;
    localparam int OFS_FLAGS   = 6;
    localparam int OFS_LEN     = 8;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 2'd2;

    localparam logic [31:0] RST_MAGIC   = 32'd0;
    localparam logic [7:0]  RST_VERSION = 8'd1;
    localparam logic [31:0] RST_MAX_LEN = 32'd16777216;

    localparam logic MODE_DATA  = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MAGIC     = 2'd1;
    localparam logic [1:0] ST_VERSION   = 2'd2;
    localparam logic [1:0] ST_TOO_LARGE = 2'd3;

    typedef struct packed {
        logic       mode;
        logic [7:0] in_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  pkt_type;
        logic [15:0] hdr_flags;
        logic [31:0] body_len;
        logic [7:0]  out_byte;
        logic [1:0]  status;
        logic        last;
    } t_out_item;

endpackage
`default_nettype wire

// ===== rtl/phd_front.sv =====
`default_nettype none
module phd_front (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_accept,
    input  phd_pkg::t_in_item                  i_item,
    input  wire                                i_cfg_we,
    input  wire  [phd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [phd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                               o_push,
    output phd_pkg::t_out_item                 o_result
);
    import phd_pkg::*;

    logic [31:0]          r_magic;
    logic [7:0]           r_version;
    logic [31:0]          r_max_len;

    logic                 r_in_payload, n_in_payload;
    logic [HDR_CNT_W-1:0] r_hdr_cnt, n_hdr_cnt;
    logic [31:0]          r_bytes_left, n_bytes_left;
    logic [8*(HDR_BYTES-1)-1:0] r_store;

    logic [31:0] w_magic;
    logic [7:0]  w_version;
    logic [7:0]  w_type;
    logic [15:0] w_flags;
    logic [31:0] w_len;
    logic [1:0]  w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic   <= RST_MAGIC;
            r_version <= RST_VERSION;
            r_max_len <= RST_MAX_LEN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAGIC:   r_magic   <= i_cfg_data[31:0];
                CFG_VERSION: r_version <= i_cfg_data[7:0];
                CFG_MAX_LEN: r_max_len <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Bytes shift in at the top: once eleven have arrived, offset k sits at
    // byte lane k and the final byte is still on the input.
    always_ff @(posedge i_clk) begin
        if (i_accept && i_item.mode == MODE_DATA && !r_in_payload) begin
            r_store <= {i_item.in_byte, r_store[8*(HDR_BYTES-1)-1:8]};
        end
    end

    assign w_magic   = r_store[8*OFS_MAGIC +: 32];
    assign w_version = r_store[8*OFS_VERSION +: 8];
    assign w_type    = r_store[8*OFS_TYPE +: 8];
    assign w_flags   = r_store[8*OFS_FLAGS +: 16];
    assign w_len     = {i_item.in_byte, r_store[8*OFS_LEN +: 24]};

    always_comb begin
        if (w_magic != r_magic) begin
            w_status = ST_MAGIC;
        end else if (w_version != r_version) begin
            w_status = ST_VERSION;
        end else if (w_len > r_max_len) begin
            w_status = ST_TOO_LARGE;
        end else begin
            w_status = ST_OK;
        end
    end

    always_comb begin
        n_in_payload = r_in_payload;
        n_hdr_cnt    = r_hdr_cnt;
        n_bytes_left = r_bytes_left;
        o_push       = 1'b0;
        o_result     = '0;
        if (i_accept) begin
            if (i_item.mode == MODE_CLEAR) begin
                // drop whatever part of a packet is open
                n_in_payload = 1'b0;
                n_hdr_cnt    = '0;
                n_bytes_left = '0;
            end else if (r_in_payload) begin
                n_bytes_left      = r_bytes_left - 32'd1;
                o_push            = 1'b1;
                o_result.kind     = KIND_PAYLOAD;
                o_result.out_byte = i_item.in_byte;
                o_result.status   = ST_OK;
                o_result.last     = (r_bytes_left == 32'd1);
                if (r_bytes_left == 32'd1) begin
                    n_in_payload = 1'b0;
                end
            end else if (r_hdr_cnt == HDR_CNT_W'(HDR_BYTES - 1)) begin
                n_hdr_cnt          = '0;
                o_push             = 1'b1;
                o_result.pkt_type  = w_type;
                o_result.hdr_flags = w_flags;
                o_result.body_len  = w_len;
                o_result.status    = w_status;
                if (w_status != ST_OK) begin
                    o_result.kind = KIND_ERROR;
                    o_result.last = 1'b1;
                end else begin
                    o_result.kind = KIND_HEADER;
                    o_result.last = (w_len == 32'd0);
                    if (w_len != 32'd0) begin
                        n_in_payload = 1'b1;
                        n_bytes_left = w_len;
                    end
                end
            end else begin
                n_hdr_cnt = r_hdr_cnt + HDR_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload <= 1'b0;
            r_hdr_cnt    <= '0;
            r_bytes_left <= '0;
        end else begin
            r_in_payload <= n_in_payload;
            r_hdr_cnt    <= n_hdr_cnt;
            r_bytes_left <= n_bytes_left;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/phd_queue.sv =====
`default_nettype none
module phd_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  phd_pkg::t_out_item  i_data,
    output logic                o_full,
    output logic                o_empty,
    input  wire                 i_pop,
    output phd_pkg::t_out_item  o_data
);
    import phd_pkg::*;

    t_out_item            r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic                 w_wr;
    logic                 w_rd;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + Q_CNT_W'(1);
                2'b01:   r_count <= r_count - Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/packet_header_deframer.sv =====
`default_nettype none
// Length-prefixed packet deframer. Takes one stream byte per cycle through
// push/full and collects a 12-byte little-endian header (magic, version,
// type, flags, length). On the twelfth byte the header is checked in the
// order magic, version, length against max_len, in that same cycle;
// a good header gives a header beat and the payload bytes that follow are
// passed through, the final one marked last (a zero length marks the
// header beat last). A bad header gives an error beat with the first
// failing check in status and the next byte starts a new header. A clear
// item drops any open packet. Parser results are combinational and land
// in a four-beat result queue, visible on the pop side the cycle after.
// full rises only when that queue is full, so with pop held high the block
// sustains one byte per cycle. The user must write configuration registers
// via the cfg port only while the stream is idle; this is not enforced.
module packet_header_deframer (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                push,
    output logic                               full,
    input  phd_pkg::t_in_item                  i_in_item,
    output logic                               empty,
    input  wire                                pop,
    output phd_pkg::t_out_item                 o_out_item,
    input  wire                                i_cfg_we,
    input  wire  [phd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [phd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import phd_pkg::*;

    logic      w_accept;
    logic      w_push;
    t_out_item w_result;

    assign w_accept = push && !full;

    phd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_item     (i_in_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_push     (w_push),
        .o_result   (w_result)
    );

    phd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_result),
        .o_full  (full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_data  (o_out_item)
    );

endmodule
`default_nettype wire
